[rtl/time_of_day_clock_with_keypad_set_defines.svh]
// Assertion macros used by the checker file of the time-of-day clock.
`ifndef TIME_OF_DAY_CLOCK_WITH_KEYPAD_SET_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_KEYPAD_SET_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define TDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked during reset.
`define TDC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tdc_pkg.sv]
// Types, constants and key decoding shared by the time-of-day clock modules.
`default_nettype none

package tdc_pkg;

    localparam int ENTRY_W = 4;
    localparam int POS_W   = 3;
    localparam int KEY_W   = 8;

    // Widths of the six time digits.
    localparam int HT_W = 2;
    localparam int HU_W = 4;
    localparam int MT_W = 3;
    localparam int MU_W = 4;
    localparam int ST_W = 3;
    localparam int SU_W = 4;

    localparam logic [KEY_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [KEY_W-1:0] ASCII_NINE = 8'd57;
    localparam logic [KEY_W-1:0] KEY_START  = 8'd49;

    localparam logic [POS_W-1:0] LAST_DIGIT_POS = 3'd5;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_ENTRY  = 3'd1,
        ST_DIGIT  = 3'd2,
        ST_SET    = 3'd3,
        ST_REJECT = 3'd4,
        ST_WRONG  = 3'd5
    } status_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    function automatic logic is_digit_key(input logic [KEY_W-1:0] k);
        return (k >= ASCII_ZERO) && (k <= ASCII_NINE);
    endfunction

    // Keys that are rejected as a menu choice while the clock is running.
    function automatic logic is_wrong_key(input logic [KEY_W-1:0] k);
        return (k == ASCII_ZERO) || ((k >= 8'd50) && (k <= ASCII_NINE)) ||
               (k == 8'd35) || (k == 8'd61) || (k == 8'd43) ||
               (k == 8'd45) || (k == 8'd42) || (k == 8'd47);
    endfunction

endpackage

`default_nettype wire

[rtl/tdc_digit_cell.sv]
// One BCD digit of the clock: a rolling counter plus one stage of the entry shift line.
`default_nettype none

module tdc_digit_cell #(
    parameter int DIGIT_W = tdc_pkg::ENTRY_W
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  tdc_pkg::cell_ctl_t           ctl,
    input  wire                          carry_in,
    input  wire [DIGIT_W-1:0]            last_value,
    input  wire [tdc_pkg::ENTRY_W-1:0]   entry_in,
    output logic [tdc_pkg::ENTRY_W-1:0]  entry_out,
    output logic [DIGIT_W-1:0]           count_q,
    output logic [DIGIT_W-1:0]           count_d,
    output logic                         carry_out
);

    logic [DIGIT_W-1:0]          count_reg;
    logic [DIGIT_W-1:0]          count_next;
    logic [tdc_pkg::ENTRY_W-1:0] entry_reg;
    logic [tdc_pkg::ENTRY_W-1:0] entry_next;
    logic                        roll;

    assign roll = carry_in && (count_reg == last_value);

    always_comb begin
        entry_next = ctl.shift ? entry_in : entry_reg;
        if (ctl.load) begin
            // The digit loaded is the one shifting in with the final key.
            count_next = entry_in[DIGIT_W-1:0];
        end else if (carry_in) begin
            count_next = roll ? '0 : count_reg + DIGIT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign count_q   = count_reg;
    assign count_d   = count_next;
    assign carry_out = roll;

endmodule

`default_nettype wire

[rtl/tdc_ctrl.sv]
// Request decoder and time-entry sequencer of the clock.
`default_nettype none

module tdc_ctrl (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             accept,
    input  wire                             cmd,
    input  wire [tdc_pkg::KEY_W-1:0]        key,
    input  wire                             entry_ok,
    output tdc_pkg::cell_ctl_t              ctl,
    output logic                            tick,
    output tdc_pkg::status_t                status_d,
    output logic [tdc_pkg::POS_W-1:0]       position_d
);

    logic                      entering_reg;
    logic                      entering_next;
    logic [tdc_pkg::POS_W-1:0] taken_reg;
    logic [tdc_pkg::POS_W-1:0] taken_next;
    logic                      key_idle;
    logic                      start;
    logic                      wrong;
    logic                      take;
    logic                      last;

    assign key_idle = accept && cmd && !entering_reg;
    assign tick     = accept && !cmd && !entering_reg;
    assign start    = key_idle && (key == tdc_pkg::KEY_START);
    assign wrong    = key_idle && tdc_pkg::is_wrong_key(key);
    assign take     = accept && cmd && entering_reg && tdc_pkg::is_digit_key(key);
    assign last     = take && (taken_reg == tdc_pkg::LAST_DIGIT_POS);

    always_comb begin
        entering_next = entering_reg;
        taken_next    = taken_reg;
        status_d      = tdc_pkg::ST_NONE;
        if (start) begin
            entering_next = 1'b1;
            taken_next    = '0;
            status_d      = tdc_pkg::ST_ENTRY;
        end else if (wrong) begin
            status_d = tdc_pkg::ST_WRONG;
        end else if (last) begin
            entering_next = 1'b0;
            taken_next    = '0;
            status_d      = entry_ok ? tdc_pkg::ST_SET : tdc_pkg::ST_REJECT;
        end else if (take) begin
            // A count past the last position restarts at the first digit.
            taken_next = (taken_reg > tdc_pkg::LAST_DIGIT_POS) ?
                         tdc_pkg::POS_W'(1) : taken_reg + tdc_pkg::POS_W'(1);
            status_d   = tdc_pkg::ST_DIGIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entering_reg <= 1'b0;
            taken_reg    <= '0;
        end else begin
            entering_reg <= entering_next;
            taken_reg    <= taken_next;
        end
    end

    assign ctl.shift  = take;
    assign ctl.load   = last && entry_ok;
    assign position_d = entering_next ? taken_next : '0;

endmodule

`default_nettype wire

[rtl/time_of_day_clock_with_keypad_set.sv]
// Top level of the 24-hour time-of-day clock with keypad time entry.
`default_nettype none

// Takes one request per clock while s_tready is high: a one-second tick or a key code. Every request
// gives exactly one registered result, in the cycle after it is accepted, holding the time
// as six BCD digits, the entry position and a status. The time sits in a
// row of six digit cells whose carries ripple from seconds to hours; the same
// cells form the shift line that collects the six entered digits, and the
// final digit loads all six at once when the entry is valid. A single output
// register parts the two sides, so s_tready stays high as long as the result
// in it is taken in the same cycle or the register is empty.
module time_of_day_clock_with_keypad_set (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] key_code
    input  wire  [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  wire         m_tready,
    // [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens, [12:9] minute_units,
    // [15:13] second_tens, [19:16] second_units, [22:20] entry_position, [23] zero
    output logic [23:0] m_tdata,
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int ENTRY_W = tdc_pkg::ENTRY_W;

    logic                      accept;
    tdc_pkg::cell_ctl_t        ctl;
    logic                      tick;
    tdc_pkg::status_t          status_d;
    logic [tdc_pkg::POS_W-1:0] position_d;
    logic                      entry_ok;

    logic [ENTRY_W-1:0] su_e, st_e, mu_e, mt_e, hu_e;
    logic [tdc_pkg::SU_W-1:0] su_d;
    logic [tdc_pkg::ST_W-1:0] st_d;
    logic [tdc_pkg::MU_W-1:0] mu_d;
    logic [tdc_pkg::MT_W-1:0] mt_d;
    logic [tdc_pkg::HU_W-1:0] hu_d;
    logic [tdc_pkg::HT_W-1:0] ht_q, ht_d;
    logic su_c, st_c, mu_c, mt_c, hu_c;
    logic [tdc_pkg::HU_W-1:0] hu_last;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Entry digits as they stand before the final shift: hour tens in the hour-units
    // cell, hour units in the minute-tens cell, minute and second tens in the unit cells.
    assign entry_ok = !((hu_e > 4'd2) || ((hu_e == 4'd2) && (mt_e > 4'd3)) ||
                        (mu_e > 4'd5) || (su_e > 4'd5));

    tdc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd        (s_tuser[0]),
        .key        (s_tdata),
        .entry_ok   (entry_ok),
        .ctl        (ctl),
        .tick       (tick),
        .status_d   (status_d),
        .position_d (position_d)
    );

    tdc_digit_cell #(.DIGIT_W(tdc_pkg::SU_W)) u_su (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl),
        .carry_in (tick), .last_value (4'd9),
        .entry_in (s_tdata[ENTRY_W-1:0]), .entry_out (su_e),
        .count_q (), .count_d (su_d), .carry_out (su_c)
    );

    tdc_digit_cell #(.DIGIT_W(tdc_pkg::ST_W)) u_st (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl),
        .carry_in (su_c), .last_value (3'd5),
        .entry_in (su_e), .entry_out (st_e),
        .count_q (), .count_d (st_d), .carry_out (st_c)
    );

    tdc_digit_cell #(.DIGIT_W(tdc_pkg::MU_W)) u_mu (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl),
        .carry_in (st_c), .last_value (4'd9),
        .entry_in (st_e), .entry_out (mu_e),
        .count_q (), .count_d (mu_d), .carry_out (mu_c)
    );

    tdc_digit_cell #(.DIGIT_W(tdc_pkg::MT_W)) u_mt (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl),
        .carry_in (mu_c), .last_value (3'd5),
        .entry_in (mu_e), .entry_out (mt_e),
        .count_q (), .count_d (mt_d), .carry_out (mt_c)
    );

    // Hour units roll over at 3 in the twenties so that 23 wraps to 00.
    assign hu_last = (ht_q == 2'd2) ? 4'd3 : 4'd9;

    tdc_digit_cell #(.DIGIT_W(tdc_pkg::HU_W)) u_hu (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl),
        .carry_in (mt_c), .last_value (hu_last),
        .entry_in (mt_e), .entry_out (hu_e),
        .count_q (), .count_d (hu_d), .carry_out (hu_c)
    );

    tdc_digit_cell #(.DIGIT_W(tdc_pkg::HT_W)) u_ht (
        .aclk (aclk), .aresetn (aresetn), .ctl (ctl),
        .carry_in (hu_c), .last_value (2'd2),
        .entry_in (hu_e), .entry_out (),
        .count_q (ht_q), .count_d (ht_d), .carry_out ()
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {1'b0, position_d, su_d, st_d, mu_d, mt_d, hu_d, ht_d};
            m_tuser_reg <= status_d;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[rtl/tdc_checker.sv]
// Port-level checks of the time-of-day clock, bound to its top level.
`default_nettype none
`include "time_of_day_clock_with_keypad_set_defines.svh"

module tdc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire [2:0]  m_tuser
);

    logic [2:0] pos;
    assign pos = m_tdata[22:20];

    `TDC_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `TDC_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `TDC_ASSERT(a_end_pos, aclk, aresetn, m_tvalid && (m_tuser == tdc_pkg::ST_SET || m_tuser == tdc_pkg::ST_REJECT || m_tuser == tdc_pkg::ST_ENTRY) |-> pos == 3'd0, "entry position not cleared")
    `TDC_ASSERT(a_digit_pos, aclk, aresetn, m_tvalid && m_tuser == tdc_pkg::ST_DIGIT |-> pos != 3'd0 && pos != 3'd6 && pos != 3'd7, "digit taken with bad position")
    `TDC_ASSERT(a_ready, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

bind time_of_day_clock_with_keypad_set tdc_checker u_tdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the time-of-day clock with keypad time entry.
`default_nettype none

module testbench;

    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 5;

    // Display fields as they sit in m_tdata, highest field first.
    typedef struct packed {
        logic                         pad;
        logic [tdc_pkg::POS_W-1:0]    position;
        logic [tdc_pkg::SU_W-1:0]     sec_units;
        logic [tdc_pkg::ST_W-1:0]     sec_tens;
        logic [tdc_pkg::MU_W-1:0]     min_units;
        logic [tdc_pkg::MT_W-1:0]     min_tens;
        logic [tdc_pkg::HU_W-1:0]     hour_units;
        logic [tdc_pkg::HT_W-1:0]     hour_tens;
    } display_t;

    typedef struct {
        display_t          disp;
        tdc_pkg::status_t  status;
    } clock_result_t;

    typedef struct {
        logic                      cmd;
        logic [tdc_pkg::KEY_W-1:0] key;
    } clock_request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    clock_request_t pending_requests[$];
    clock_result_t  expected_display[$];
    int             errors = 0;
    int             cycle_count = 0;
    logic           calm = 1'b0;

    // Predictor state.
    int  time_h = 0, time_m = 0, time_s = 0;
    bit  entering = 1'b0;
    int  digits_taken = 0;
    int  new_h = 0, new_m = 0, new_s = 0;

    time_of_day_clock_with_keypad_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit menu_reject_key(input logic [tdc_pkg::KEY_W-1:0] k);
        return k inside {"0", ["2":"9"], "#", "=", "+", "-", "*", "/"};
    endfunction

    function automatic void advance_time();
        if (time_s >= 59) begin
            time_s = 0;
            if (time_m >= 59) begin
                time_m = 0;
                time_h = (time_h >= 23) ? 0 : time_h + 1;
            end else begin
                time_m++;
            end
        end else begin
            time_s++;
        end
    endfunction

    function automatic void predict_clock(input logic cmd,
                                          input logic [tdc_pkg::KEY_W-1:0] key);
        tdc_pkg::status_t st;
        int               d;
        clock_result_t    r;
        st = tdc_pkg::ST_NONE;
        if (!cmd) begin
            if (!entering) advance_time();
        end else if (!entering) begin
            if (key == tdc_pkg::KEY_START) begin
                entering = 1'b1;
                digits_taken = 0;
                new_h = 0;
                new_m = 0;
                new_s = 0;
                st = tdc_pkg::ST_ENTRY;
            end else if (menu_reject_key(key)) begin
                st = tdc_pkg::ST_WRONG;
            end
        end else if (key >= tdc_pkg::ASCII_ZERO && key <= tdc_pkg::ASCII_NINE) begin
            d = int'(key - tdc_pkg::ASCII_ZERO);
            // Even positions start a field with the tens digit.
            case (digits_taken / 2)
                0: new_h = (digits_taken % 2 == 0) ? d * 10 : new_h + d;
                1: new_m = (digits_taken % 2 == 0) ? d * 10 : new_m + d;
                default: new_s = (digits_taken % 2 == 0) ? d * 10 : new_s + d;
            endcase
            digits_taken++;
            st = tdc_pkg::ST_DIGIT;
            if (digits_taken >= 6) begin
                if (new_h > 23 || new_m > 59 || new_s > 59) begin
                    st = tdc_pkg::ST_REJECT;
                end else begin
                    time_h = new_h;
                    time_m = new_m;
                    time_s = new_s;
                    st = tdc_pkg::ST_SET;
                end
                entering = 1'b0;
                digits_taken = 0;
            end
        end
        r.disp.pad        = 1'b0;
        r.disp.position   = entering ? tdc_pkg::POS_W'(digits_taken) : '0;
        r.disp.hour_tens  = tdc_pkg::HT_W'(time_h / 10);
        r.disp.hour_units = tdc_pkg::HU_W'(time_h % 10);
        r.disp.min_tens   = tdc_pkg::MT_W'(time_m / 10);
        r.disp.min_units  = tdc_pkg::MU_W'(time_m % 10);
        r.disp.sec_tens   = tdc_pkg::ST_W'(time_s / 10);
        r.disp.sec_units  = tdc_pkg::SU_W'(time_s % 10);
        r.status          = st;
        expected_display.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_request(input logic cmd,
                                         input logic [tdc_pkg::KEY_W-1:0] key);
        clock_request_t q;
        q.cmd = cmd;
        q.key = key;
        pending_requests.push_back(q);
    endfunction

    function automatic void push_digits(input string digits);
        for (int i = 0; i < digits.len(); i++) push_request(1'b1, digits[i]);
    endfunction

    function automatic logic [tdc_pkg::KEY_W-1:0] non_digit_key();
        int r;
        r = $urandom_range(0, 245);
        if (r >= 48) r += 10;
        return tdc_pkg::KEY_W'(r);
    endfunction

    // A start key and up to six digits, with occasional ignored requests mixed in.
    function automatic void push_entry(input bit want_valid, input int ndigits);
        int v[6];
        int h, m, s;
        if (want_valid) begin
            h = $urandom_range(0, 23);
            m = $urandom_range(0, 59);
            s = $urandom_range(0, 59);
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) h = 23;
                m = 59;
                s = $urandom_range(55, 59);
            end
            v = '{h / 10, h % 10, m / 10, m % 10, s / 10, s % 10};
        end else begin
            foreach (v[i]) v[i] = $urandom_range(0, 9);
        end
        push_request(1'b1, tdc_pkg::KEY_START);
        for (int i = 0; i < ndigits; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_request(1'b0, tdc_pkg::KEY_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) push_request(1'b1, non_digit_key());
            push_request(1'b1, tdc_pkg::ASCII_ZERO + tdc_pkg::KEY_W'(v[i]));
        end
    endfunction

    function automatic void fill_random();
        int r;
        logic [tdc_pkg::KEY_W-1:0] k;
        while (pending_requests.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                push_entry($urandom_range(0, 2) != 0, 6);
            end else if (r < 50) begin
                push_entry(1'b0, $urandom_range(1, 5));
            end else if (r < 80) begin
                repeat ($urandom_range(1, 12))
                    push_request(1'b0, tdc_pkg::KEY_W'($urandom_range(0, 255)));
            end else begin
                k = tdc_pkg::KEY_W'($urandom_range(0, 255));
                if (k == tdc_pkg::KEY_START) k = ~k;
                push_request(1'b1, k);
            end
        end
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Request driver.
    clock_request_t cur_request;
    int             send_gap = 0;
    always @(posedge aclk) begin
        logic busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_clock(cur_request.cmd, cur_request.key);
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    cur_request = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_request.key;
                    s_tuser  <= cur_request.cmd;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    int recv_stall = 0;
    always @(posedge aclk) begin
        display_t      got;
        clock_result_t want;
        logic          ready_next;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = display_t'(m_tdata);
                if (expected_display.size() == 0) begin
                    $error("result with no request outstanding: data %h status %0d",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = expected_display.pop_front();
                    check_field("hour_tens", want.disp.hour_tens, got.hour_tens);
                    check_field("hour_units", want.disp.hour_units, got.hour_units);
                    check_field("minute_tens", want.disp.min_tens, got.min_tens);
                    check_field("minute_units", want.disp.min_units, got.min_units);
                    check_field("second_tens", want.disp.sec_tens, got.sec_tens);
                    check_field("second_units", want.disp.sec_units, got.sec_units);
                    check_field("entry_position", want.disp.position, got.position);
                    check_field("pad", want.disp.pad, got.pad);
                    check_field("status", want.status, m_tuser);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if ($urandom_range(0, 99) < 30) recv_stall = pick_gap();
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("time_of_day_clock_with_keypad_set verification failed");
            $finish;
        end
    end

    initial begin
        // Directed: ticks, menu keys, ignored requests, a set to the last second
        // of the day with its wrap, and a rejected entry.
        push_request(1'b0, 8'hFF);
        push_request(1'b1, 8'h00);
        push_request(1'b1, 8'hFF);
        push_request(1'b1, "0");
        push_request(1'b1, "9");
        push_request(1'b1, "#");
        push_request(1'b1, tdc_pkg::KEY_START);
        push_request(1'b0, 8'h00);
        push_request(1'b1, "A");
        push_digits("235959");
        push_request(1'b0, 8'h00);
        push_request(1'b1, tdc_pkg::KEY_START);
        push_digits("999999");
        fill_random();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_requests.size() > 0 || s_tvalid || expected_display.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("time_of_day_clock_with_keypad_set verification clean");
        end else begin
            $display("time_of_day_clock_with_keypad_set verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/tdc_pkg.sv
rtl/tdc_digit_cell.sv
rtl/tdc_ctrl.sv
rtl/time_of_day_clock_with_keypad_set.sv
rtl/tdc_checker.sv
tb/testbench.sv
